FILE: rtl/ifpyu_pkg.sv
// Shared constants, codes and structs for the IMU frame parser with yaw unwrap.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ifpyu_pkg;

	// Item kinds on the input channel
	localparam logic [1:0] MODE_BYTE = 2'd0;
	localparam logic [1:0] MODE_YAW  = 2'd1;
	localparam logic [1:0] MODE_ZERO = 2'd2;

	// Frame layout
	localparam logic [7:0] FRAME_HEADER = 8'h55;
	localparam logic [7:0] TYPE_RATE    = 8'h52;
	localparam logic [7:0] TYPE_ANGLE   = 8'h53;
	localparam int         FRAME_LEN    = 11;
	localparam int         IDX_W        = 4;
	localparam logic [IDX_W-1:0] SUM_IDX  = 4'd10;
	localparam logic [IDX_W-1:0] BODY_END = 4'd7;
	localparam int         BODY_LEN     = 7;

	// Angle arithmetic: 32768 raw units = half turn
	localparam logic signed [16:0] HALF_TURN = 17'sd32768;
	localparam logic signed [17:0] FULL_TURN = 18'sd65536;

	localparam logic [15:0] TIMEOUT_RESET = 16'd200;

	// Frame decoder event for the current byte
	typedef struct packed {
		logic               ok;
		logic               bad;
		logic               push;
		logic signed [15:0] yaw;
	} frame_evt_t;

	// Yaw push / zero request into the unwrap unit
	typedef struct packed {
		logic               push;
		logic               zero;
		logic signed [15:0] yaw;
		logic [31:0]        now;
	} yaw_cmd_t;

	// Unwrap unit state as seen by the report stage
	typedef struct packed {
		logic signed [15:0] yaw;
		logic signed [31:0] cont;
		logic signed [31:0] offset;
		logic [31:0]        count;
		logic [31:0]        last_ms;
	} yaw_state_t;

	// Latest decoded attitude values
	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] rate_z;
	} attitude_t;

	// One result item
	typedef struct packed {
		logic               frame_accepted;
		logic               checksum_error;
		logic signed [15:0] roll_raw;
		logic signed [15:0] pitch_raw;
		logic signed [15:0] yaw_raw;
		logic signed [15:0] rate_z_raw;
		logic signed [31:0] yaw_relative;
		logic [31:0]        push_count;
		logic               alive;
	} result_t;

endpackage

FILE: rtl/ifpyu_in_if.sv
// Input channel interface: valid/ready handshake with the input item payload.
// No dependencies.
`timescale 1ns / 1ps

interface ifpyu_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [7:0]         data_byte;
	logic signed [15:0] yaw_in;
	logic [31:0]        now_ms;

	modport source (output valid, mode, data_byte, yaw_in, now_ms, input ready);
	modport sink   (input valid, mode, data_byte, yaw_in, now_ms, output ready);
endinterface

FILE: rtl/ifpyu_out_if.sv
// Result channel interface: valid/ready handshake with the result item payload.
// No dependencies.
`timescale 1ns / 1ps

interface ifpyu_out_if;
	logic               valid;
	logic               ready;
	logic               frame_accepted;
	logic               checksum_error;
	logic signed [15:0] roll_raw;
	logic signed [15:0] pitch_raw;
	logic signed [15:0] yaw_raw;
	logic signed [15:0] rate_z_raw;
	logic signed [31:0] yaw_relative;
	logic [31:0]        push_count;
	logic               alive;

	modport source (output valid, frame_accepted, checksum_error, roll_raw, pitch_raw,
		yaw_raw, rate_z_raw, yaw_relative, push_count, alive, input ready);
	modport sink   (input valid, frame_accepted, checksum_error, roll_raw, pitch_raw,
		yaw_raw, rate_z_raw, yaw_relative, push_count, alive, output ready);
endinterface

FILE: rtl/imu_frame_parser_yaw_unwrap_core.sv
// Top level of the IMU frame parser with yaw unwrap: input register, state
// update stage, result register. Depends on ifpyu_pkg, the two channel
// interfaces, ifpyu_frame, ifpyu_yaw and ifpyu_report.
`timescale 1ns / 1ps

// Takes one item per clock unless stalled: serial bytes of 0x55-headed 11-byte
// frames, external yaw samples or zero-yaw commands, and returns exactly one
// result per item. Items pass three registers (input, state update, result);
// throughput is one item every cycle while nothing stalls. The checksum
// is kept as a running sum so the closing byte needs only an 8-bit compare.
// Back-pressure on the result channel stalls the stages from the output
// backwards, each stage still accepting as the one ahead of it drains. The
// alive timeout register may be written only while no item is in flight.

module imu_frame_parser_yaw_unwrap_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	ifpyu_in_if.sink    in_ch,
	ifpyu_out_if.source out_ch
);
	import ifpyu_pkg::*;

	logic               v_s1, v_s2, v_s3;
	logic               rdy1, rdy2, rdy3;
	logic               adv1, load3;
	logic [1:0]         mode_s1;
	logic [7:0]         byte_s1;
	logic signed [15:0] yaw_s1;
	logic [31:0]        now_s1;
	logic               ok_s2, bad_s2;
	logic [31:0]        now_s2;
	logic [15:0]        timeout_q;

	frame_evt_t frm_evt;
	attitude_t  att;
	yaw_cmd_t   ycmd;
	yaw_state_t yst;
	result_t    res;

	// Stall chain from the result side back to the input
	assign rdy3        = !v_s3 || out_ch.ready;
	assign rdy2        = !v_s2 || rdy3;
	assign rdy1        = !v_s1 || rdy2;
	assign in_ch.ready = rdy1;
	assign adv1        = v_s1 && rdy2;
	assign load3       = v_s2 && rdy3;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_ch.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (in_ch.valid && rdy1) begin
			mode_s1 <= in_ch.mode;
			byte_s1 <= in_ch.data_byte;
			yaw_s1  <= in_ch.yaw_in;
			now_s1  <= in_ch.now_ms;
		end
	end

	// Timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_data;
		end
	end

	// Frame gathering, updated as an item leaves the input register
	ifpyu_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (adv1 && (mode_s1 == MODE_BYTE)),
		.data_byte (byte_s1),
		.evt       (frm_evt),
		.att       (att)
	);

	// Yaw push from an angle frame or the external feed
	always_comb begin
		ycmd.push = adv1 && ((mode_s1 == MODE_YAW) || frm_evt.push);
		ycmd.zero = adv1 && (mode_s1 == MODE_ZERO);
		ycmd.yaw  = frm_evt.push ? frm_evt.yaw : yaw_s1;
		ycmd.now  = now_s1;
	end

	ifpyu_yaw u_yaw (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ycmd),
		.st     (yst)
	);

	// Per-item flags travelling with the state update stage
	always_ff @(posedge clk) begin
		if (adv1) begin
			ok_s2  <= frm_evt.ok;
			bad_s2 <= frm_evt.bad;
			now_s2 <= now_s1;
		end
	end

	ifpyu_report u_report (
		.clk        (clk),
		.load       (load3),
		.ok         (ok_s2),
		.bad        (bad_s2),
		.now_ms     (now_s2),
		.timeout_ms (timeout_q),
		.att        (att),
		.st         (yst),
		.res        (res)
	);

	// Result channel
	assign out_ch.valid          = v_s3;
	assign out_ch.frame_accepted = res.frame_accepted;
	assign out_ch.checksum_error = res.checksum_error;
	assign out_ch.roll_raw       = res.roll_raw;
	assign out_ch.pitch_raw      = res.pitch_raw;
	assign out_ch.yaw_raw        = res.yaw_raw;
	assign out_ch.rate_z_raw     = res.rate_z_raw;
	assign out_ch.yaw_relative   = res.yaw_relative;
	assign out_ch.push_count     = res.push_count;
	assign out_ch.alive          = res.alive;

`ifndef SYNTHESIS
	// a closing byte is either good or bad, never both
	a_frame_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(frm_evt.ok && frm_evt.bad))
		else $error("frame reported good and bad at once");

	// after any push the counter is non-zero
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		ycmd.push |=> (yst.count != '0))
		else $error("push counter zero after a push");

	// a zero command makes the offset equal the continuous yaw
	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		ycmd.zero |=> (yst.offset == yst.cont))
		else $error("offset not latched on zero command");

	// frame events only come from serial bytes
	a_evt_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(frm_evt.ok || frm_evt.bad) |-> (adv1 && (mode_s1 == MODE_BYTE)))
		else $error("frame event outside a serial byte transfer");
`endif

endmodule

FILE: rtl/ifpyu_frame.sv
// Serial frame gatherer: byte position, running checksum, body store and
// rate/roll/pitch registers. Depends on ifpyu_pkg.
`timescale 1ns / 1ps

module ifpyu_frame (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [7:0]             data_byte,
	output ifpyu_pkg::frame_evt_t  evt,
	output ifpyu_pkg::attitude_t   att
);
	import ifpyu_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic [7:0]       sum_q;
	logic [7:0]       body_q [BODY_LEN];
	attitude_t        att_q;

	logic             at_end;
	logic             in_body;
	logic [2:0]       body_sel;
	logic [7:0]       frame_type;
	logic signed [15:0] v0, v1, v2;

	// Decode of the stored frame body (bytes 1..7)
	assign frame_type = body_q[0];
	assign v0         = {body_q[2], body_q[1]};
	assign v1         = {body_q[4], body_q[3]};
	assign v2         = {body_q[6], body_q[5]};

	assign at_end   = take && (idx_q == SUM_IDX);
	assign in_body  = (idx_q != '0) && (idx_q <= BODY_END);
	assign body_sel = 3'(idx_q - 4'd1);

	always_comb begin
		evt.ok   = at_end && (sum_q == data_byte);
		evt.bad  = at_end && (sum_q != data_byte);
		evt.push = evt.ok && (frame_type == TYPE_ANGLE);
		evt.yaw  = v2;
	end

	assign att = att_q;

	// Byte position and running checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sum_q <= '0;
		end else if (take) begin
			if (idx_q == '0) begin
				if (data_byte == FRAME_HEADER) begin
					idx_q <= 4'd1;
					sum_q <= data_byte;
				end
			end else if (idx_q == SUM_IDX) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 4'd1;
				sum_q <= sum_q + data_byte;
			end
		end
	end

	// Frame body store, no reset
	always_ff @(posedge clk) begin
		if (take && in_body) begin
			body_q[body_sel] <= data_byte;
		end
	end

	// Latest rate and angles from good frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q <= '0;
		end else if (evt.ok) begin
			if (frame_type == TYPE_RATE) begin
				att_q.rate_z <= v2;
			end else if (frame_type == TYPE_ANGLE) begin
				att_q.roll  <= v0;
				att_q.pitch <= v1;
			end
		end
	end

endmodule

FILE: rtl/ifpyu_yaw.sv
// Yaw unwrap unit: continuous yaw with half-turn wrap, zero offset, push
// counter and last push time. Depends on ifpyu_pkg.
`timescale 1ns / 1ps

module ifpyu_yaw (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ifpyu_pkg::yaw_cmd_t    cmd,
	output ifpyu_pkg::yaw_state_t  st
);
	import ifpyu_pkg::*;

	logic signed [15:0] prev_q;
	logic               first_q;
	yaw_state_t         st_q;

	logic signed [17:0] step_raw;
	logic signed [17:0] step;
	logic signed [32:0] cont_sum;
	logic signed [31:0] cont_sat;

	// Step from previous yaw, folded into a half turn either way
	always_comb begin
		step_raw = 18'(cmd.yaw) - 18'(prev_q);
		if (step_raw > 18'(HALF_TURN)) begin
			step = step_raw - FULL_TURN;
		end else if (step_raw < -18'(HALF_TURN)) begin
			step = step_raw + FULL_TURN;
		end else begin
			step = step_raw;
		end
		cont_sum = 33'(st_q.cont) + 33'(step);
		if (cont_sum[32] != cont_sum[31]) begin
			cont_sat = cont_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			cont_sat = cont_sum[31:0];
		end
	end

	assign st = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			first_q <= 1'b1;
			st_q    <= '0;
		end else if (cmd.push) begin
			// first push aligns continuous yaw to the absolute yaw
			st_q.cont    <= first_q ? 32'(cmd.yaw) : cont_sat;
			first_q      <= 1'b0;
			prev_q       <= cmd.yaw;
			st_q.yaw     <= cmd.yaw;
			st_q.last_ms <= cmd.now;
			if (st_q.count != '1) begin
				st_q.count <= st_q.count + 32'd1;
			end
		end else if (cmd.zero) begin
			st_q.offset <= st_q.cont;
		end
	end

endmodule

FILE: rtl/ifpyu_report.sv
// Result stage: relative yaw with saturation, alive test and the result
// register. Depends on ifpyu_pkg.
`timescale 1ns / 1ps

module ifpyu_report (
	input  logic                   clk,
	input  logic                   load,
	input  logic                   ok,
	input  logic                   bad,
	input  logic [31:0]            now_ms,
	input  logic [15:0]            timeout_ms,
	input  ifpyu_pkg::attitude_t   att,
	input  ifpyu_pkg::yaw_state_t  st,
	output ifpyu_pkg::result_t     res
);
	import ifpyu_pkg::*;

	result_t            res_s3;
	logic signed [32:0] rel_wide;
	logic signed [31:0] rel_sat;
	logic [31:0]        age;

	// Continuous yaw minus offset, clipped to 32 bits
	always_comb begin
		rel_wide = 33'(st.cont) - 33'(st.offset);
		if (rel_wide[32] != rel_wide[31]) begin
			rel_sat = rel_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			rel_sat = rel_wide[31:0];
		end
		age = now_ms - st.last_ms;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s3.frame_accepted <= ok;
			res_s3.checksum_error <= bad;
			res_s3.roll_raw       <= att.roll;
			res_s3.pitch_raw      <= att.pitch;
			res_s3.yaw_raw        <= st.yaw;
			res_s3.rate_z_raw     <= att.rate_z;
			res_s3.yaw_relative   <= rel_sat;
			res_s3.push_count     <= st.count;
			res_s3.alive          <= (st.count != '0) && (age < 32'(timeout_ms));
		end
	end

	assign res = res_s3;

endmodule

FILE: tb/tb.sv
// Self-checking bench for imu_frame_parser_yaw_unwrap_core: drives bytes, yaw feeds and zero
// commands, predicts each unpinned result from its model of frame parsing and yaw unwrapping.
// Depends on ifpyu_pkg, ifpyu_in_if, ifpyu_out_if and the core RTL.
`timescale 1ns / 1ps

module tb;
	import ifpyu_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam result_t    NO_RESULT   = '0;
	localparam longint     S32_MAX     = 64'sd2147483647;
	localparam longint     S32_MIN     = -64'sd2147483648;

	typedef struct {
		logic [1:0]         mode;
		logic [7:0]         data;
		logic signed [15:0] yaw;
		logic [31:0]        now;
		bit                 pinned;
		result_t            res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_data;

	ifpyu_in_if  in_ch ();
	ifpyu_out_if out_ch ();

	imu_frame_parser_yaw_unwrap_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// Model of the block's state
	logic [7:0]         frame_buf [FRAME_LEN];
	logic [3:0]         frame_pos    = '0;
	logic signed [15:0] roll_q       = '0;
	logic signed [15:0] pitch_q      = '0;
	logic signed [15:0] yaw_q        = '0;
	logic signed [15:0] rate_q       = '0;
	logic signed [15:0] yaw_prev_q   = '0;
	int                 unwrapped_yaw = 0;
	int                 yaw_zero     = 0;
	logic [31:0]        push_total   = '0;
	logic [31:0]        last_push_ms = '0;
	bit                 awaiting_first = 1'b1;
	logic [15:0]        timeout_ms   = TIMEOUT_RESET;

	// Bench bookkeeping
	result_t   awaited_results [$];
	stim_row_t directed_rows [$];
	bit        pin_on;
	result_t   pin_res;
	result_t   predicted, observed, wanted;
	int        tx_idle_pct, rx_stall_pct;
	logic [31:0] ms_clock = '0;
	int        err_count, xfer_count, good_frames, bad_frames;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int clamp_s32(input longint v);
		if (v > S32_MAX) return int'(S32_MAX);
		if (v < S32_MIN) return int'(S32_MIN);
		return int'(v);
	endfunction

	// Push one yaw sample into the unwrapper
	function automatic void push_yaw_sample(input logic signed [15:0] y, input logic [31:0] now);
		int step;
		if (awaiting_first) begin
			yaw_prev_q     = y;
			unwrapped_yaw  = int'(y);
			awaiting_first = 1'b0;
		end
		step = int'(y) - int'(yaw_prev_q);
		// only steps beyond half a turn are folded back
		if (step > HALF_TURN) step -= FULL_TURN;
		if (step < -HALF_TURN) step += FULL_TURN;
		unwrapped_yaw = clamp_s32(longint'(unwrapped_yaw) + step);
		yaw_prev_q    = y;
		yaw_q         = y;
		if (push_total != '1) push_total++;
		last_push_ms = now;
	endfunction

	// Advance the model by one item and return the result it reports
	function automatic result_t parse_and_unwrap(input logic [1:0] m, input logic [7:0] b,
			input logic signed [15:0] y, input logic [31:0] now);
		result_t     r;
		logic [7:0]  sum;
		logic [31:0] age;
		r = '0;
		case (m)
			MODE_BYTE: begin
				// bytes before a header are dropped
				if (!(frame_pos == 0 && b != FRAME_HEADER)) begin
					frame_buf[frame_pos] = b;
					if (frame_pos != SUM_IDX) begin
						frame_pos++;
					end else begin
						frame_pos = '0;
						sum = '0;
						for (int i = 0; i < SUM_IDX; i++) sum += frame_buf[i];
						if (sum != frame_buf[SUM_IDX]) begin
							r.checksum_error = 1'b1;
						end else begin
							r.frame_accepted = 1'b1;
							if (frame_buf[1] == TYPE_RATE) begin
								rate_q = {frame_buf[7], frame_buf[6]};
							end else if (frame_buf[1] == TYPE_ANGLE) begin
								roll_q  = {frame_buf[3], frame_buf[2]};
								pitch_q = {frame_buf[5], frame_buf[4]};
								push_yaw_sample({frame_buf[7], frame_buf[6]}, now);
							end
						end
					end
				end
			end
			MODE_YAW:  push_yaw_sample(y, now);
			MODE_ZERO: yaw_zero = unwrapped_yaw;
			default: ;
		endcase
		age = now - last_push_ms;
		r.roll_raw     = roll_q;
		r.pitch_raw    = pitch_q;
		r.yaw_raw      = yaw_q;
		r.rate_z_raw   = rate_q;
		r.yaw_relative = clamp_s32(longint'(unwrapped_yaw) - longint'(yaw_zero));
		r.push_count   = push_total;
		r.alive        = (push_total != 0) && (age < {16'd0, timeout_ms});
		return r;
	endfunction

	function automatic string show_res(input result_t r);
		return $sformatf("acc=%0b err=%0b roll=%0d pitch=%0d yaw=%0d rate=%0d rel=%0d cnt=%0d alive=%0b",
			r.frame_accepted, r.checksum_error, r.roll_raw, r.pitch_raw, r.yaw_raw,
			r.rate_z_raw, r.yaw_relative, r.push_count, r.alive);
	endfunction

	task automatic flag_error(input string what, input result_t want, input result_t got);
		err_count++;
		if (err_count <= 10) begin
			$display("%0t: %s", $time, what);
			$display("  expected %s", show_res(want));
			$display("  actual   %s", show_res(got));
		end
	endtask

	// Record accepted items, check returned results against the oldest expectation
	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			predicted = parse_and_unwrap(in_ch.mode, in_ch.data_byte, in_ch.yaw_in, in_ch.now_ms);
			xfer_count++;
			if (predicted.frame_accepted) good_frames++;
			if (predicted.checksum_error) bad_frames++;
			awaited_results.push_back(pin_on ? pin_res : predicted);
		end
		if (out_ch.valid && out_ch.ready) begin
			observed = {out_ch.frame_accepted, out_ch.checksum_error, out_ch.roll_raw,
				out_ch.pitch_raw, out_ch.yaw_raw, out_ch.rate_z_raw, out_ch.yaw_relative,
				out_ch.push_count, out_ch.alive};
			if (awaited_results.size() == 0) begin
				flag_error("result with nothing outstanding", NO_RESULT, observed);
			end else begin
				wanted = awaited_results.pop_front();
				if (observed !== wanted) flag_error("result mismatch", wanted, observed);
			end
		end
	end

	// Result-side back-pressure
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// One transfer on the input channel, with random sender gaps ahead of it
	task automatic send_item(input logic [1:0] m, input logic [7:0] b,
			input logic signed [15:0] y, input logic [31:0] now,
			input bit pin, input result_t res);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.mode      <= m;
		in_ch.data_byte <= b;
		in_ch.yaw_in    <= y;
		in_ch.now_ms    <= now;
		pin_on          <= pin;
		pin_res         <= res;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	// Hold the sender off until every outstanding result is back
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] v);
		cfg_data <= v;
		cfg_we   <= 1'b1;
		@(negedge clk);
		cfg_we     <= 1'b0;
		timeout_ms = v;
	endtask

	// Millisecond stamp: mostly small steps, now and then a jump anywhere
	function automatic logic [31:0] advance_ms();
		int r;
		r = $urandom_range(99);
		if (r < 30) ;
		else if (r < 80) ms_clock += $urandom_range(0, 300);
		else if (r < 95) ms_clock += $urandom_range(0, 70000);
		else ms_clock = $urandom;
		return ms_clock;
	endfunction

	function automatic logic signed [15:0] pick_yaw();
		int r;
		r = $urandom_range(99);
		if (r < 35) return 16'($urandom);
		if (r < 75) return 16'(int'(yaw_prev_q) + int'($urandom_range(0, 2000)) - 1000);
		if (r < 85) return yaw_prev_q + 16'sh8000;   // exactly half a turn away
		if (r < 92) return yaw_prev_q + 16'sh8001;   // around half a turn
		return r[0] ? 16'sh7FFF : 16'sh8000;
	endfunction

	// Mostly whole frames with random content; some corrupt, cut short, or noise
	task automatic run_random(input int target);
		int          sent, pick, n;
		logic [7:0]  fb [FRAME_LEN];
		logic [7:0]  ck;
		logic signed [15:0] y;
		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(99);
			if (pick < 62) begin
				fb[0] = FRAME_HEADER;
				n = $urandom_range(99);
				fb[1] = (n < 50) ? TYPE_ANGLE : (n < 80) ? TYPE_RATE : 8'($urandom);
				{fb[3], fb[2]} = 16'($urandom);
				{fb[5], fb[4]} = 16'($urandom);
				y = pick_yaw();
				{fb[7], fb[6]} = y;
				fb[8] = 8'($urandom);
				fb[9] = 8'($urandom);
				ck = '0;
				for (int i = 0; i < SUM_IDX; i++) ck += fb[i];
				if ($urandom_range(99) < 12) ck += 8'($urandom_range(1, 255));
				fb[SUM_IDX] = ck;
				n = ($urandom_range(99) < 8) ? $urandom_range(2, FRAME_LEN - 1) : FRAME_LEN;
				for (int i = 0; i < n; i++)
					send_item(MODE_BYTE, fb[i], 16'($urandom), advance_ms(), 1'b0, NO_RESULT);
				sent += n;
			end else if (pick < 80) begin
				send_item(MODE_YAW, 8'($urandom), pick_yaw(), advance_ms(), 1'b0, NO_RESULT);
				sent++;
			end else if (pick < 86) begin
				send_item(MODE_ZERO, 8'($urandom), 16'($urandom), advance_ms(), 1'b0, NO_RESULT);
				sent++;
			end else if (pick < 89) begin
				send_item(MODE_UNUSED, 8'($urandom), 16'($urandom), advance_ms(), 1'b0,
					NO_RESULT);
			end else begin
				send_item(MODE_BYTE, 8'($urandom), 16'($urandom), advance_ms(), 1'b0, NO_RESULT);
			end
		end
	endtask

	initial begin
		logic [15:0] last_timeout;
		in_ch.valid     = 1'b0;
		in_ch.mode      = MODE_BYTE;
		in_ch.data_byte = '0;
		in_ch.yaw_in    = '0;
		in_ch.now_ms    = '0;
		out_ch.ready    = 1'b0;
		cfg_we          = 1'b0;
		cfg_data        = '0;
		pin_on          = 1'b0;
		pin_res         = NO_RESULT;
		tx_idle_pct     = 17;
		rx_stall_pct    = 45;
		err_count       = 0;
		xfer_count      = 0;
		good_frames     = 0;
		bad_frames      = 0;
		arst_n          = 1'b0;

		// Directed: stray byte, unused mode, zero with no pushes, yaw wrap and
		// exact half turns, one angle frame at the field extremes
		directed_rows.push_back(stim_row_t'{MODE_BYTE, 8'h00, 16'sh1234, 32'd0, 1'b1, NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_UNUSED, 8'hFF, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1,
			NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_ZERO, 8'hAA, 16'sh8000, 32'd5, 1'b1, NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_YAW, FRAME_HEADER, 16'sh8000, 32'd100, 1'b1,
			result_t'{1'b0, 1'b0, 16'sd0, 16'sd0, 16'sh8000, 16'sd0, -32'sd32768, 32'd1, 1'b1}});
		directed_rows.push_back(stim_row_t'{MODE_YAW, 8'h00, 16'sh0000, 32'd299, 1'b0, NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_YAW, 8'hFF, 16'sh7FFF, 32'd499, 1'b0, NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_YAW, 8'h0F, 16'sh8000, 32'd500, 1'b0, NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_ZERO, 8'hF0, 16'sh7FFF, 32'd699, 1'b0, NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_BYTE, 8'h00, 16'sh0000, 32'd700, 1'b0, NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_YAW, 8'h5A, 16'sh0000, 32'hFFFF_FFFF, 1'b0,
			NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_BYTE, FRAME_HEADER, 16'sh5A5A, 32'd0, 1'b0,
			NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_BYTE, TYPE_ANGLE, 16'shA5A5, 32'd1, 1'b0,
			NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_BYTE, 8'h00, 16'sh5A5A, 32'd2, 1'b0, NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_BYTE, 8'h80, 16'shA5A5, 32'd3, 1'b0, NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_BYTE, 8'hFF, 16'sh5A5A, 32'd4, 1'b0, NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_BYTE, 8'h7F, 16'shA5A5, 32'd5, 1'b0, NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_BYTE, 8'h00, 16'sh5A5A, 32'd6, 1'b0, NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_BYTE, 8'h80, 16'shA5A5, 32'd7, 1'b0, NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_BYTE, 8'h00, 16'sh5A5A, 32'd8, 1'b0, NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_BYTE, 8'h00, 16'shA5A5, 32'd9, 1'b0, NO_RESULT});
		directed_rows.push_back(stim_row_t'{MODE_BYTE, 8'h26, 16'sh5A5A, 32'd10, 1'b1,
			result_t'{1'b1, 1'b0, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sd0, 32'sd0, 32'd6, 1'b1}});

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[k])
			send_item(directed_rows[k].mode, directed_rows[k].data, directed_rows[k].yaw,
				directed_rows[k].now, directed_rows[k].pinned, directed_rows[k].res);

		// Random phases, each behind a full drain and a timeout write
		drain_results();
		write_timeout(16'd1);
		run_random(90);

		tx_idle_pct  = 45;
		rx_stall_pct = 17;
		drain_results();
		write_timeout(16'hFFFF);
		ms_clock = 32'hFFFF_F000;
		run_random(100);

		drain_results();
		write_timeout(16'd0);
		run_random(90);

		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		drain_results();
		last_timeout = 16'($urandom_range(1, 65535));
		write_timeout(last_timeout);
		run_random(220);

		drain_results();
		repeat (8) @(negedge clk);

		$display("Run covered %0d transfers: %0d good frames, %0d checksum failures, %0d yaw pushes",
			xfer_count, good_frames, bad_frames, push_total);
		$display("Alive timeout stepped through 200, 1, 65535, 0 and %0d ms; %0d mismatches",
			last_timeout, err_count);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
